>>> design/wsd_pkg.sv
// Shared types and constants for the websocket frame deframer.
// No dependencies; imported by wsd_parser and websocket_frame_deframer.
package wsd_pkg;

	typedef enum logic [2:0] {
		ST_PAYLOAD       = 3'd0,
		ST_EMPTY         = 3'd1,
		ST_FRAG_CTRL     = 3'd2,
		ST_EMPTY_PING    = 3'd3,
		ST_UNMASKED_PING = 3'd4
	} wsd_status_t;

	localparam logic [3:0] OPC_CLOSE = 4'd8;
	localparam logic [3:0] OPC_PING  = 4'd9;
	localparam logic [3:0] OPC_PONG  = 4'd10;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [3:0]  frame_opcode;
		logic        final_fragment;
		logic        end_of_frame;
		wsd_status_t result_status;
	} wsd_res_t;

endpackage

>>> design/wsd_parser.sv
// Frame header decoder and payload unmasker: one byte per step.
// Depends on wsd_pkg for the result struct, status codes and opcodes.
module wsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              emit,
	output wsd_pkg::wsd_res_t res
);
	import wsd_pkg::*;

	typedef enum logic {
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        fin_q, fin_d;
	logic [3:0]  opc_q, opc_d;
	logic        mask_q, mask_d;
	logic [6:0]  short_q, short_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  idx_q, idx_d;

	logic [3:0]  ext_old, ext_new, total;
	logic        finish, last, is_ctrl;
	logic [7:0]  key_byte;

	function automatic logic [3:0] ext_len(input logic [6:0] sl);
		logic [3:0] r;
		r = 4'd0;
		if (sl == LEN_EXT16) r = 4'd2;
		else if (sl == LEN_EXT64) r = 4'd8;
		return r;
	endfunction

	assign ext_old = ext_len(short_q);
	assign is_ctrl = opc_q[3];
	assign last    = (rem_q == 64'd0);

	always_comb begin
		case (idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		if (!mask_q) key_byte = 8'd0;
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		fin_d   = fin_q;
		opc_d   = opc_q;
		mask_d  = mask_q;
		short_d = short_q;
		len_d   = len_q;
		key_d   = key_q;
		rem_d   = rem_q;
		idx_d   = idx_q;
		ext_new = ext_old;
		total   = 4'd0;
		finish  = 1'b0;
		emit    = 1'b0;
		res.payload_byte   = 8'd0;
		res.frame_opcode   = opc_q;
		res.final_fragment = fin_q;
		res.end_of_frame   = 1'b1;
		res.result_status  = ST_EMPTY;

		if (phase_q == PH_HEADER) begin
			if (cnt_q == 4'd0) begin
				fin_d = rx_byte[7];
				opc_d = rx_byte[3:0];
				cnt_d = 4'd1;
			end else begin
				if (cnt_q == 4'd1) begin
					mask_d  = rx_byte[7];
					short_d = rx_byte[6:0];
					ext_new = ext_len(rx_byte[6:0]);
					len_d   = (ext_new == 4'd0) ? {57'd0, rx_byte[6:0]} : 64'd0;
					cnt_d   = 4'd2;
				end else begin
					if (cnt_q < 4'd2 + ext_old) len_d = {len_q[55:0], rx_byte};
					else key_d = {key_q[23:0], rx_byte};
					cnt_d = cnt_q + 4'd1;
				end
				total  = 4'd2 + ext_new + (mask_d ? 4'd4 : 4'd0);
				finish = (cnt_d >= total);
			end
			if (finish) begin
				cnt_d = 4'd0;
				if (len_d != 64'd0) begin
					phase_d = PH_PAYLOAD;
					rem_d   = len_d - 64'd1;
					idx_d   = 2'd0;
				end else begin
					// empty frame: one event result
					emit = 1'b1;
					if (is_ctrl && !fin_q)
						res.result_status = ST_FRAG_CTRL;
					else if (opc_q == OPC_PING || opc_q == OPC_PONG)
						res.result_status = ST_EMPTY_PING;
				end
			end
		end else begin
			rem_d = rem_q - 64'd1;
			idx_d = idx_q + 2'd1;
			if (last) begin
				phase_d = PH_HEADER;
				cnt_d   = 4'd0;
			end
			if (is_ctrl && !fin_q) begin
				emit = last;
				res.result_status = ST_FRAG_CTRL;
			end else if (opc_q == OPC_PING && !mask_q) begin
				emit = last;
				res.result_status = ST_UNMASKED_PING;
			end else if (is_ctrl && opc_q != OPC_CLOSE && opc_q != OPC_PING) begin
				// drop pong and reserved control payload
				emit = 1'b0;
			end else begin
				emit = 1'b1;
				res.payload_byte  = rx_byte ^ key_byte;
				res.end_of_frame  = last;
				res.result_status = ST_PAYLOAD;
			end
		end
		if (!step) emit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= 4'd0;
			fin_q   <= 1'b0;
			opc_q   <= 4'd0;
			mask_q  <= 1'b0;
			short_q <= 7'd0;
			len_q   <= 64'd0;
			key_q   <= 32'd0;
			rem_q   <= 64'd0;
			idx_q   <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			opc_q   <= opc_d;
			mask_q  <= mask_d;
			short_q <= short_d;
			len_q   <= len_d;
			key_q   <= key_d;
			rem_q   <= rem_d;
			idx_q   <= idx_d;
		end
	end

endmodule

>>> design/websocket_frame_deframer.sv
// Top level of the websocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg and wsd_parser.
//
//  channel | handshake         | payload
//  --------+-------------------+--------------------------------------------------
//  in      | in_valid/in_stall | rx_byte
//  out     | out_valid/out_stall | payload_byte, frame_opcode, final_fragment,
//          |                   | end_of_frame, result_status
//
// One byte per cycle sustained unless out stalls; parser results are registered in res_q.
// The parser step sits between the input register and the result register.
// Reset clears all parser state, so the first byte is taken as a frame header.
// A stall on out with out_valid high holds the result register and a full input register,
// and in_stall rises only when both are full.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic [3:0]  frame_opcode,
	output logic        final_fragment,
	output logic        end_of_frame,
	output logic [2:0]  result_status
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv, step, emit;
	logic       out_valid_q;
	wsd_res_t   res, res_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_byte   = res_q.payload_byte;
	assign frame_opcode   = res_q.frame_opcode;
	assign final_fragment = res_q.final_fragment;
	assign end_of_frame   = res_q.end_of_frame;
	assign result_status  = res_q.result_status;

endmodule
